@@ design/utf8_stream_decoder_core_defines.svh @@
// Assertion macros used by the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_CORE_DEFINES_SVH
`define UTF8_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define U8SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/utf8sd_pkg.sv @@
// Shared types and constants of the UTF-8 stream decoder.
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned CountWidth = 3;

  localparam logic [7:0] LeadMask2 = 8'b1110_0000;
  localparam logic [7:0] LeadMask3 = 8'b1111_0000;
  localparam logic [7:0] LeadMask4 = 8'b1111_1000;
  localparam logic [7:0] LeadCode2 = 8'b1100_0000;
  localparam logic [7:0] LeadCode3 = 8'b1110_0000;
  localparam logic [7:0] LeadCode4 = 8'b1111_0000;
  localparam logic [7:0] ContMask  = 8'h3f;

  localparam logic [CpWidth-1:0] SurrLo = 21'h00_d800;
  localparam logic [CpWidth-1:0] SurrHi = 21'h00_dfff;

  localparam logic [CountWidth-1:0] Len1 = 3'd1;
  localparam logic [CountWidth-1:0] Len2 = 3'd2;
  localparam logic [CountWidth-1:0] Len3 = 3'd3;
  localparam logic [CountWidth-1:0] Len4 = 3'd4;

  // Decoded request leaving the decode stage.
  typedef struct packed {
    logic                  valid;
    logic [CpWidth-1:0]    code_point;
    logic [CountWidth-1:0] byte_count;
  } result_t;

endpackage

`default_nettype wire

@@ design/utf8sd_in_reg.sv @@
// Input register of the UTF-8 stream decoder.
`default_nettype none

module utf8sd_in_reg
  import utf8sd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       advance,
  output logic            item_valid,
  output logic [7:0]      item_byte
);

  // Slot is free when empty or when its byte moves on this cycle.
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_byte <= data_byte;
    end
  end

endmodule

`default_nettype wire

@@ design/utf8sd_decode.sv @@
// Sequence state and per-byte decode of the UTF-8 stream decoder.
`default_nettype none
`include "utf8_stream_decoder_core_defines.svh"

module utf8sd_decode
  import utf8sd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  input  wire logic [7:0] item_byte,
  input  wire logic       advance,
  output result_t         result
);

  logic [1:0]            bytes_pending,   bytes_pending_next;
  logic [CpWidth-1:0]    partial_value,   partial_value_next;
  logic [CountWidth-1:0] sequence_length, sequence_length_next;
  logic [CpWidth-1:0]    raw_value;
  logic                  fire;

  assign fire = item_valid && advance;

  always_comb begin
    bytes_pending_next   = bytes_pending;
    partial_value_next   = partial_value;
    sequence_length_next = sequence_length;
    raw_value            = '0;
    result.valid         = 1'b0;
    result.byte_count    = Len1;
    if (bytes_pending != 2'd0) begin
      raw_value          = {partial_value[CpWidth-7:0], item_byte[5:0] & ContMask[5:0]};
      bytes_pending_next = bytes_pending - 2'd1;
      if (bytes_pending == 2'd1) begin
        result.valid         = 1'b1;
        result.byte_count    = sequence_length;
        partial_value_next   = '0;
        sequence_length_next = '0;
      end else begin
        partial_value_next = raw_value;
      end
    end else begin
      priority if (!item_byte[7]) begin
        result.valid = 1'b1;
        raw_value    = {{(CpWidth-7){1'b0}}, item_byte[6:0]};
      end else if ((item_byte & LeadMask2) == LeadCode2) begin
        partial_value_next   = {{(CpWidth-5){1'b0}}, item_byte[4:0]};
        bytes_pending_next   = 2'd1;
        sequence_length_next = Len2;
      end else if ((item_byte & LeadMask3) == LeadCode3) begin
        partial_value_next   = {{(CpWidth-4){1'b0}}, item_byte[3:0]};
        bytes_pending_next   = 2'd2;
        sequence_length_next = Len3;
      end else if ((item_byte & LeadMask4) == LeadCode4) begin
        partial_value_next   = {{(CpWidth-3){1'b0}}, item_byte[2:0]};
        bytes_pending_next   = 2'd3;
        sequence_length_next = Len4;
      end else begin
        // invalid lead: emit zero, one byte
        result.valid = 1'b1;
      end
    end
    // surrogates decode to zero
    if (raw_value >= SurrLo && raw_value <= SurrHi) begin
      result.code_point = '0;
    end else begin
      result.code_point = raw_value;
    end
    if (!item_valid) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= 2'd0;
      partial_value   <= '0;
      sequence_length <= '0;
    end else if (fire) begin
      bytes_pending   <= bytes_pending_next;
      partial_value   <= partial_value_next;
      sequence_length <= sequence_length_next;
    end
  end

  `U8SD_ASSERT_NOW(a_idle_clean, bytes_pending == 2'd0, partial_value == '0 && sequence_length == '0, "idle state not clear")
  `U8SD_ASSERT_NOW(a_len_ahead, bytes_pending != 2'd0, sequence_length > {1'b0, bytes_pending} && sequence_length <= Len4, "length/pending mismatch")
  `U8SD_ASSERT_NOW(a_multi_end, result.valid && result.byte_count != Len1, bytes_pending == 2'd1, "multi-byte result off last byte")
  `U8SD_ASSERT_NEXT(a_count_down, fire && bytes_pending != 2'd0, bytes_pending == $past(bytes_pending) - 2'd1, "pending did not count down")

endmodule

`default_nettype wire

@@ design/utf8sd_out_reg.sv @@
// Result register of the UTF-8 stream decoder.
`default_nettype none

module utf8sd_out_reg
  import utf8sd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  result_t               result,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [CpWidth-1:0]    code_point,
  output logic [CountWidth-1:0] byte_count
);

  // Register may load when empty or when its request leaves now.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      code_point <= result.code_point;
      byte_count <= result.byte_count;
    end
  end

endmodule

`default_nettype wire

@@ design/utf8_stream_decoder_core.sv @@
// Top level of the byte-serial UTF-8 stream decoder.
//
// Input channel: one raw byte per request (data_byte) under in_valid/in_stall.
// Output channel: one decoded code point per completed sequence (code_point,
// byte_count) under out_valid/out_stall. Lead bytes of length 2..4 and their
// continuation bytes produce no output until the last byte arrives; an ASCII
// byte or an invalid lead byte produces a result on its own.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single decode stage that holds the open-sequence state and updates it per byte.
// A byte accepted into the input register is decoded into the result register
// once that register can load, and its result is offered from then.
// When the receiver stalls, the result register holds its request; an empty
// input register still takes one more byte, then in_stall stays high until
// the held request leaves.
// Reset (rst, synchronous) empties both registers and closes any open sequence.
`default_nettype none

module utf8_stream_decoder_core
  import utf8sd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       data_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [CpWidth-1:0]    code_point,
  output logic [CountWidth-1:0] byte_count
);

  logic       advance;
  logic       item_valid;
  logic [7:0] item_byte;
  result_t    result;

  // Input register: parts the upstream handshake from the decode logic.
  utf8sd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  // Decode: sequence state plus masks and shifts for one byte.
  utf8sd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .advance    (advance),
    .result     (result)
  );

  // Result register: holds a request until the receiver takes it.
  utf8sd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .byte_count (byte_count)
  );

endmodule

`default_nettype wire
